[rtl/core/extent_bitmap_allocator_top_assert.svh]
// assertion macros used by the checker file
`ifndef EXTENT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define EXTENT_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, held off in reset
`define EBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eba assertion failed");

// next-cycle implication
`define EBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eba assertion failed");

`endif

[rtl/core/eba_pkg.sv]
`timescale 1ns / 1ps
package eba_pkg;

  localparam int unsigned EXTENTS = 64;
  localparam int unsigned IDX_W   = $clog2(EXTENTS);
  localparam int unsigned EXT_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  // word index of the base offset register
  localparam logic REG_BASE_OFFSET = 1'b0;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_LIST    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [CNT_W-1:0] count;
    logic [EXT_W-1:0] extent;
    logic [CNT_W-1:0] start_index;
  } eba_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_id;
    logic              valid_res;
    logic              last;
    logic              full_res;
    logic [CNT_W-1:0]  granted;
  } eba_out_t;

  // what the probe unit reports about the current map position
  typedef struct packed {
    logic              hit;
    logic              at_end;
    logic [PAGE_W-1:0] page;
  } probe_t;

endpackage

[rtl/core/eba_probe.sv]
`timescale 1ns / 1ps
module eba_probe
  import eba_pkg::*;
(
  input  logic [EXTENTS-1:0] map_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic               alloc_i,
  input  logic [PAGE_W-1:0]  base_i,
  output probe_t             probe_o
);

  logic free_bit;

  assign free_bit = map_i[idx_i];

  // allocate looks for free extents, list for taken ones
  assign probe_o.hit    = alloc_i ? free_bit : !free_bit;
  assign probe_o.at_end = (idx_i == IDX_W'(EXTENTS - 1));
  assign probe_o.page   = base_i + PAGE_W'(idx_i);

endmodule

[rtl/core/extent_bitmap_allocator_top.sv]
`timescale 1ns / 1ps
// Extent allocator over a 64-bit free map with a next-fit pointer. Each input beat is
// one command: allocate (scan forward from the pointer, no wrap, granting up to count
// extents), deallocate (free one extent, no result, ready again next cycle), list
// (every taken extent from start_index on) or query full (state of the final extent).
// Allocate and list walk the map one extent per cycle through a single probe unit
// (bit select plus base offset adder), except while the output side stalls a result;
// the input is stalled for the whole command. Each result is held back one hit so the
// last flag can be set once the scan ends. base_offset sits at byte address 0 of the
// register port. The user must only write it idle; the block does not enforce this.
module extent_bitmap_allocator_top
  import eba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  eba_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output eba_out_t          out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [EXTENTS-1:0] map_q, map_d;
  logic [IDX_W-1:0]   next_ptr_q, next_ptr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   got_q, got_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               alloc_q, alloc_d;
  logic               full_q, full_d;
  logic               pend_q, pend_d;
  logic [PAGE_W-1:0]  pend_page_q, pend_page_d;
  logic [CNT_W-1:0]   pend_granted_q, pend_granted_d;
  logic               out_valid_q, out_valid_d;
  eba_out_t           out_q, out_d;
  logic [PAGE_W-1:0]  base_q;
  logic               can_push;
  logic               cfg_wr;
  probe_t             probe;

  eba_probe u_probe (
    .map_i   (map_q),
    .idx_i   (idx_q),
    .alloc_i (alloc_q),
    .base_i  (base_q),
    .probe_o (probe)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BASE_OFFSET);
  assign prdata = (paddr[2] == REG_BASE_OFFSET) ? base_q : '0;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_push    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    map_d          = map_q;
    next_ptr_d     = next_ptr_q;
    idx_d          = idx_q;
    got_d          = got_q;
    count_d        = count_q;
    alloc_d        = alloc_q;
    full_d         = full_q;
    pend_d         = pend_q;
    pend_page_d    = pend_page_q;
    pend_granted_d = pend_granted_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_d  = 1'b0;
          full_d  = 1'b0;
          got_d   = '0;
          count_d = in_data_i.count;
          unique case (in_data_i.command)
            CMD_ALLOC: begin
              alloc_d = 1'b1;
              idx_d   = next_ptr_q;
              state_d = ST_SCAN;
            end
            CMD_DEALLOC: begin
              if ({1'b0, in_data_i.extent} < (EXT_W + 1)'(EXTENTS)) begin
                map_d[in_data_i.extent[IDX_W-1:0]] = 1'b1;
              end
            end
            CMD_LIST: begin
              alloc_d = 1'b0;
              if (in_data_i.start_index < CNT_W'(EXTENTS)) begin
                idx_d   = in_data_i.start_index[IDX_W-1:0];
                state_d = ST_SCAN;
              end else begin
                state_d = ST_FIN;
              end
            end
            CMD_QUERY: begin
              full_d  = !map_q[EXTENTS-1];
              state_d = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (alloc_q && (got_q == count_q)) begin
          state_d = ST_FIN;
        end else if (!(probe.hit && pend_q && !can_push)) begin
          if (probe.hit) begin
            // the held result is now known not to be the last one
            if (pend_q) begin
              out_valid_d     = 1'b1;
              out_d.page_id   = pend_page_q;
              out_d.valid_res = 1'b1;
              out_d.last      = 1'b0;
              out_d.full_res  = 1'b0;
              out_d.granted   = pend_granted_q;
            end
            pend_d      = 1'b1;
            pend_page_d = probe.page;
            if (alloc_q) begin
              map_d[idx_q]   = 1'b0;
              next_ptr_d     = idx_q;
              got_d          = got_q + CNT_W'(1);
              pend_granted_d = got_q + CNT_W'(1);
            end else begin
              pend_granted_d = '0;
            end
          end
          if (probe.at_end) begin
            state_d = ST_FIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (can_push) begin
          out_valid_d    = 1'b1;
          out_d.last     = 1'b1;
          out_d.full_res = full_q;
          if (pend_q) begin
            out_d.page_id   = pend_page_q;
            out_d.valid_res = 1'b1;
            out_d.granted   = pend_granted_q;
          end else begin
            // marker beat: nothing granted or listed
            out_d.page_id   = '0;
            out_d.valid_res = 1'b0;
            out_d.granted   = '0;
          end
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      map_q       <= '1;
      next_ptr_q  <= '0;
      idx_q       <= '0;
      got_q       <= '0;
      count_q     <= '0;
      alloc_q     <= 1'b0;
      full_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      next_ptr_q  <= next_ptr_d;
      idx_q       <= idx_d;
      got_q       <= got_d;
      count_q     <= count_d;
      alloc_q     <= alloc_d;
      full_q      <= full_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        base_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_page_q    <= pend_page_d;
    pend_granted_q <= pend_granted_d;
    out_q          <= out_d;
  end

endmodule

[rtl/core/eba_chk.sv]
`timescale 1ns / 1ps
`include "extent_bitmap_allocator_top_assert.svh"
module eba_chk
  import eba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input eba_in_t           in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input eba_out_t          out_data_o
);

  logic in_beat;
  logic busy_cmd;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign busy_cmd = (in_data_i.command != CMD_DEALLOC);

  // a stalled result stays offered
  `EBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // every command except deallocate keeps the input stalled while it runs
  `EBA_ASSERT_NEXT(a_busy_after_cmd, in_beat && busy_cmd, in_stall_o)

  // a marker beat always closes its command
  `EBA_ASSERT_IMPL(a_marker_last, out_valid_o && !out_data_o.valid_res, out_data_o.last)

  // the full flag only rides on a single marker beat
  `EBA_ASSERT_IMPL(a_full_marker, out_valid_o && out_data_o.full_res,
                   !out_data_o.valid_res && out_data_o.last && (out_data_o.granted == '0))

endmodule

bind extent_bitmap_allocator_top eba_chk u_eba_chk (.*);
